@@ rtl/double_prefix_sum_poisson_solve_defines.svh @@
// Assertion macros used by the RTL of the double prefix sum solver.
`ifndef DOUBLE_PREFIX_SUM_POISSON_SOLVE_DEFINES_SVH
`define DOUBLE_PREFIX_SUM_POISSON_SOLVE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPSPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define DPSPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/dpsps_pkg.sv @@
`default_nettype none
package dpsps_pkg;

   localparam int SAMPLE_W = 32;
   localparam int PREFIX_W = 42;
   localparam int VALUE_W  = 52;
   localparam int INDEX_W  = 10;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef enum logic {
      STATUS_OK    = 1'b0,
      STATUS_EMPTY = 1'b1
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage
`default_nettype wire

@@ rtl/dpsps_if.sv @@
`default_nettype none
interface dpsps_req_if import dpsps_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface dpsps_rsp_if import dpsps_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic        [INDEX_W-1:0] index;
   logic                      last;
   logic                      status;

   modport source (output valid, output value, output index, output last, output status,
                   input ready);
   modport sink   (input valid, input value, input index, input last, input status,
                   output ready);
endinterface
`default_nettype wire

@@ rtl/double_prefix_sum_poisson_solve.sv @@
// On a load, the new prefix is written to the prefix memory in the cycle it transfers.
// A read of a stored element first addresses the prefix memory, whose read data is registered,
// and then adds it to the running suffix into the output register.
// A read with nothing stored gives an empty status without addressing the prefix memory.
// Synchronous reset clears the counters, running sums, phase and output valid; the prefix memory
// is not cleared, as only entries written since the last restart are ever read.
`default_nettype none
`include "double_prefix_sum_poisson_solve_defines.svh"
module double_prefix_sum_poisson_solve import dpsps_pkg::*; #(
   parameter int DEPTH = 1024
) (
   input  wire logic   clock,
   input  wire logic   reset,
   dpsps_req_if.sink   req_ch,
   dpsps_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type state_ff, state_in;

   logic        [CW-1:0]       cnt_ff, cnt_in;
   logic        [CW-1:0]       cnt_dec;
   logic                       reading_ff, reading_in;
   logic signed [PREFIX_W-1:0] prefix_ff, prefix_in;
   logic signed [PREFIX_W-1:0] prefix_sum;
   logic signed [SAMPLE_W-1:0] sample_sel;
   logic signed [VALUE_W-1:0]  suffix_ff, suffix_in;
   logic signed [VALUE_W-1:0]  suffix_sum;

   logic        [PREFIX_W-1:0] mem_array [DEPTH];
   logic signed [PREFIX_W-1:0] rd_data_ff;
   logic        [AW-1:0]       rd_addr;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   logic        [INDEX_W-1:0]  index_ff, index_in;
   logic                       last_ff, last_in;
   logic                       status_ff, status_in;

   logic req_ready;
   logic load_go;
   logic read_go;
   logic empty_read;
   logic fetch;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fetch) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs. A new item is taken only when the output register is free or draining.
   always_comb begin
      req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
      load_go    = req_ch.valid && req_ready && (req_ch.cmd == CMD_LOAD) && !reading_ff
                   && (cnt_ff != CW'(DEPTH));
      read_go    = req_ch.valid && req_ready && (req_ch.cmd == CMD_READ);
      empty_read = read_go && (cnt_ff == '0);
      fetch      = read_go && (cnt_ff != '0);
   end

   assign req_ch.ready  = req_ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = value_ff;
   assign rsp_ch.index  = index_ff;
   assign rsp_ch.last   = last_ff;
   assign rsp_ch.status = status_ff;

   assign cnt_dec    = cnt_ff - CW'(1);
   assign rd_addr    = cnt_dec[AW-1:0];
   // The first sample after a restart is halved.
   assign sample_sel = (cnt_ff == '0) ? (req_ch.sample >>> 1) : req_ch.sample;
   assign prefix_sum = prefix_ff + PREFIX_W'(sample_sel);
   assign suffix_sum = suffix_ff + VALUE_W'(rd_data_ff);

   always_comb begin
      cnt_in       = cnt_ff;
      reading_in   = reading_ff;
      prefix_in    = prefix_ff;
      suffix_in    = suffix_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      value_in     = value_ff;
      index_in     = index_ff;
      last_in      = last_ff;
      status_in    = status_ff;

      if (load_go) begin
         prefix_in = prefix_sum;
         cnt_in    = cnt_ff + CW'(1);
      end

      if (empty_read) begin
         rsp_valid_in = 1'b1;
         value_in     = '0;
         index_in     = '0;
         last_in      = 1'b0;
         status_in    = STATUS_EMPTY;
      end

      if (fetch) begin
         cnt_in     = cnt_dec;
         reading_in = 1'b1;
      end

      if (state_ff == ST_READ) begin
         rsp_valid_in = 1'b1;
         value_in     = suffix_sum;
         index_in     = INDEX_W'(cnt_ff);
         last_in      = (cnt_ff == '0);
         status_in    = STATUS_OK;
         if (cnt_ff == '0) begin
            // Index 0 has gone out, so the block restarts.
            prefix_in  = '0;
            suffix_in  = '0;
            reading_in = 1'b0;
         end else begin
            suffix_in = suffix_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         reading_ff   <= 1'b0;
         prefix_ff    <= '0;
         suffix_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         reading_ff   <= reading_in;
         prefix_ff    <= prefix_in;
         suffix_ff    <= suffix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      index_ff  <= index_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   // Prefix memory: one write port for loads, one registered read port for reads.
   always_ff @(posedge clock) begin
      if (load_go) begin
         mem_array[cnt_ff[AW-1:0]] <= prefix_sum;
      end
      if (fetch) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   `DPSPS_ASSERT_NEXT(a_read_one_cycle, clock, reset, state_ff == ST_READ, state_ff == ST_IDLE)
   `DPSPS_ASSERT_SAME(a_out_free_on_fetch, clock, reset, state_ff == ST_READ, !rsp_valid_ff)
   `DPSPS_ASSERT_NEXT(a_fetch_then_read, clock, reset, fetch, state_ff == ST_READ)
   `DPSPS_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, cnt_ff <= CW'(DEPTH))
   `DPSPS_ASSERT_SAME(a_empty_not_last, clock, reset,
                      rsp_valid_ff && (status_ff == STATUS_EMPTY), !last_ff)

endmodule
`default_nettype wire
